// File: rtl/mpbd_pkg.sv
package mpbd_pkg;

    localparam int MaxWidth   = 4096;
    localparam int MaxHeight  = 16384;
    localparam int LevelSlots = 13;
    localparam int LvW        = 4;
    localparam int ColW       = 13;
    localparam int RowW       = 15;
    localparam int SlotW      = 12;

    localparam logic [0:0] CFG_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [LvW-1:0]  level;
        logic [10:0]     x_pos;
        logic [12:0]     y_pos;
        logic [31:0]     pixel_out;
        logic            last;
    } result_t;

    function automatic logic [35:0] lane_pair(input logic [31:0] a, input logic [31:0] b);
        logic [35:0] s;
        for (int k = 0; k < 4; k++)
        begin
            s[9*k +: 9] = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
        end
        return s;
    endfunction

    function automatic logic [31:0] lane_mean(input logic [35:0] t, input logic [35:0] u);
        logic [31:0] r;
        logic [9:0]  v;
        for (int k = 0; k < 4; k++)
        begin
            v = {1'b0, t[9*k +: 9]} + {1'b0, u[9*k +: 9]};
            r[8*k +: 8] = v[9:2];
        end
        return r;
    endfunction

endpackage

// File: rtl/mpbd_pair_ram.sv
module mpbd_pair_ram (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [mpbd_pkg::SlotW-1:0] wr_addr,
    input  logic [35:0]                wr_data,
    input  logic [mpbd_pkg::SlotW-1:0] rd_addr,
    output logic [35:0]                rd_data
);
    logic [35:0] mem [mpbd_pkg::MaxWidth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// File: rtl/mipmap_pyramid_box_downsample_unit.sv
// each result of a pixel passes through the steps walk, memory read and emit, one level
//   after another, before it reaches the output register
// a new pixel is taken only once the level walk for the last one has ended; the walk
//   runs over one pair-sum memory port
// input also waits while a second result sits in the output skid
// reset: positions cleared, sizes 4096 x 4096; the memories need no clearing
module mipmap_pyramid_box_downsample_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pixel
    input  logic        s_tuser,   // first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // level[3:0], x_pos[14:4], y_pos[27:15], pixel_out[59:28]
    output logic        m_tlast,   // last
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [14:0] cfg_data
);
    typedef enum logic [1:0] {IDLE, WALK, READ, EMIT} state_t;

    state_t state_reg;
    logic [12:0] w_reg;
    logic [14:0] h_reg;
    logic [12:0] col_reg [mpbd_pkg::LevelSlots];
    logic [14:0] row_reg [mpbd_pkg::LevelSlots];
    logic [mpbd_pkg::LvW-1:0] lv_reg;
    logic [31:0] p_reg;
    logic [31:0] left_mem [mpbd_pkg::LevelSlots];
    logic [35:0] pair_reg;
    logic [11:0] slot_reg;   // pair-sum entry of the level being emitted
    logic [11:0] x_reg;
    logic [12:0] y_reg;
    mpbd_pkg::result_t out_reg;
    logic out_valid_reg;
    mpbd_pkg::result_t hold_reg;
    logic        hold_valid_reg;

    // effective sizes
    logic [12:0] we;
    logic [14:0] he;
    assign we = (w_reg == '0) ? 13'd1 : (w_reg > 13'd4096 ? 13'd4096 : w_reg);
    assign he = (h_reg == '0) ? 15'd1 : (h_reg > 15'd16384 ? 15'd16384 : h_reg);

    logic [12:0] lw;
    logic [14:0] lh;
    logic [12:0] cx;
    logic [14:0] cy;
    assign lw = we >> lv_reg;
    assign lh = he >> lv_reg;
    assign cx = col_reg[lv_reg];
    assign cy = row_reg[lv_reg];

    logic [11:0] slot;
    assign slot = 12'(13'd4096 - (13'd4096 >> lv_reg) + 13'(cx >> 1));

    logic        ram_we;
    logic [35:0] ram_q;
    logic [35:0] pair_now;
    assign pair_now = mpbd_pkg::lane_pair(left_mem[lv_reg], p_reg);

    logic walk_fire;
    logic in_range;
    assign in_range = (cx < {lw[12:1], 1'b0}) && (cy < {lh[14:1], 1'b0});
    assign walk_fire = (state_reg == WALK) && (lw != '0) && (lh != '0) &&
        (lv_reg < mpbd_pkg::LvW'(mpbd_pkg::LevelSlots - 1));
    assign ram_we = walk_fire && in_range && cx[0] && !cy[0];

    // positions restart on a register write or a transfer in that marks a new image
    logic restart;
    assign restart = cfg_we || ((state_reg == IDLE) && s_tvalid && s_tready && s_tuser);

    mpbd_pair_ram u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (slot),
        .wr_data (pair_now),
        .rd_addr (slot_reg),
        .rd_data (ram_q)
    );

    // look one level ahead: the emitted result is last unless the next level completes too
    logic [mpbd_pkg::LvW-1:0] nx;
    logic [12:0] lwn;
    logic [14:0] lhn;
    logic [12:0] cxn;
    logic [14:0] cyn;
    logic        next_emits;
    assign nx  = lv_reg + 4'd1;
    assign lwn = we >> nx;
    assign lhn = he >> nx;
    assign cxn = (nx < mpbd_pkg::LvW'(mpbd_pkg::LevelSlots)) ? col_reg[nx] : '0;
    assign cyn = (nx < mpbd_pkg::LvW'(mpbd_pkg::LevelSlots)) ? row_reg[nx] : '0;
    assign next_emits = (nx < mpbd_pkg::LvW'(mpbd_pkg::LevelSlots - 1)) &&
        (lwn != '0) && (lhn != '0) &&
        (cxn < {lwn[12:1], 1'b0}) && (cyn < {lhn[14:1], 1'b0}) && cxn[0] && cyn[0];

    // output side: a two-entry skid (out + hold) so the walk never loses results
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg.pixel_out, out_reg.y_pos, out_reg.x_pos, out_reg.level};
    assign m_tlast  = out_reg.last;
    assign s_tready = (state_reg == IDLE) && !hold_valid_reg;

    logic emit_fire;
    logic out_pop;
    mpbd_pkg::result_t emit_res;
    logic stop_walk;
    // emit waits only while both skid entries are full and the receiver stalls
    assign emit_fire = (state_reg == EMIT) && !(hold_valid_reg && !m_tready);
    assign out_pop   = out_valid_reg && m_tready;
    always_comb
    begin
        emit_res.level     = lv_reg + 4'd1;
        emit_res.x_pos     = x_reg[11:1];
        emit_res.y_pos     = y_reg;
        emit_res.pixel_out = mpbd_pkg::lane_mean(ram_q, pair_reg);
        emit_res.last      = !next_emits;
    end
    // the walk ends on a level that produces nothing
    assign stop_walk = (state_reg == WALK) && !(walk_fire && in_range && cx[0] && cy[0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            w_reg <= 13'd4096;
            h_reg <= 15'd4096;
            for (int i = 0; i < mpbd_pkg::LevelSlots; i++)
            begin
                col_reg[i] <= '0;
                row_reg[i] <= '0;
            end
            lv_reg <= '0;
            out_valid_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mpbd_pkg::CFG_WIDTH:  w_reg <= cfg_data[12:0];
                    mpbd_pkg::CFG_HEIGHT: h_reg <= cfg_data;
                    default: ;
                endcase
            end

            // per-level positions
            if (restart)
            begin
                for (int i = 0; i < mpbd_pkg::LevelSlots; i++)
                begin
                    col_reg[i] <= '0;
                    row_reg[i] <= '0;
                end
            end
            else if (walk_fire)
            begin
                if (cx + 13'd1 >= lw)
                begin
                    col_reg[lv_reg] <= '0;
                    row_reg[lv_reg] <= (cy + 15'd1 >= lh) ? '0 : cy + 15'd1;
                end
                else
                begin
                    col_reg[lv_reg] <= cx + 13'd1;
                end
            end

            // output register and skid
            if (out_pop)
            begin
                if (hold_valid_reg)
                begin
                    out_reg <= hold_reg;
                    if (emit_fire)
                        hold_reg <= emit_res;
                    else
                        hold_valid_reg <= 1'b0;
                end
                else if (emit_fire)
                begin
                    out_reg <= emit_res;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (emit_fire)
            begin
                if (!out_valid_reg)
                begin
                    out_reg <= emit_res;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    hold_reg <= emit_res;
                    hold_valid_reg <= 1'b1;
                end
            end

            case (state_reg)
                IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        p_reg <= s_tdata;
                        lv_reg <= '0;
                        state_reg <= WALK;
                    end
                end
                WALK:
                begin
                    if (walk_fire && in_range && !cx[0])
                    begin
                        left_mem[lv_reg] <= p_reg;
                    end
                    pair_reg <= pair_now;
                    slot_reg <= slot;
                    x_reg <= cx[11:0];
                    y_reg <= cy[13:1];
                    if (stop_walk)
                        state_reg <= IDLE;
                    else
                        state_reg <= READ;
                end
                READ:
                begin
                    state_reg <= EMIT;
                end
                EMIT:
                begin
                    if (emit_fire)
                    begin
                        p_reg <= emit_res.pixel_out;
                        lv_reg <= lv_reg + 4'd1;
                        state_reg <= WALK;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    // input is only taken when no result is parked in the skid
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> !hold_valid_reg)
        else $error("transfer in with skid occupied");
    // skid entry implies output register full
    assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> out_valid_reg)
        else $error("skid full while output empty");
    // results only come from the read pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == EMIT) |-> $past(state_reg == READ) || $past(state_reg == EMIT))
        else $error("emit without memory read");
endmodule
